>>> rtl/srect_pkg.sv
// shared widths, term bundle and edge indices for the segment/rectangle hit test
`timescale 1ns / 1ps
`default_nettype none

package srect_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_W     = COORD_BITS - 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int OFF_W      = COORD_BITS + 2;
    localparam int MUL_W      = 2 * COORD_BITS + 3;
    localparam int TERM_W     = 2 * COORD_BITS + 4;

    localparam int NUM_EDGES   = 4;
    localparam int EDGE_TOP    = 0;
    localparam int EDGE_BOTTOM = 1;
    localparam int EDGE_LEFT   = 2;
    localparam int EDGE_RIGHT  = 3;

    typedef struct packed {
        logic signed [TERM_W-1:0] den;
        logic signed [TERM_W-1:0] n1;
        logic signed [TERM_W-1:0] n2;
    } edge_terms_t;

endpackage

`default_nettype wire

>>> rtl/srect_edge_test.sv
// exact parametric test of one rectangle edge from its denominator and numerators
`timescale 1ns / 1ps
`default_nettype none

module srect_edge_test
    import srect_pkg::*;
(
    input  edge_terms_t terms,
    output logic        hit
);

    logic den_zero;
    logic den_neg;
    logic n1_ok;
    logic n2_ok;

    function automatic logic ratio_ok(input logic signed [TERM_W-1:0] num,
                                      input logic signed [TERM_W-1:0] den,
                                      input logic                     neg);
        logic num_neg;
        logic num_zero;
        begin
            num_neg  = num[TERM_W-1];
            num_zero = (num == '0);
            if (!neg)
            begin
                ratio_ok = !num_neg && (num <= den);
            end
            else
            begin
                ratio_ok = (num_neg || num_zero) && (num >= den);
            end
        end
    endfunction

    always_comb
    begin
        den_zero = (terms.den == '0);
        den_neg  = terms.den[TERM_W-1];
        n1_ok    = ratio_ok(terms.n1, terms.den, den_neg);
        n2_ok    = ratio_ok(terms.n2, terms.den, den_neg);
        if (den_zero)
        begin
            // parallel or degenerate: collinear counts as a hit
            hit = (terms.n1 == '0) && (terms.n2 == '0);
        end
        else
        begin
            hit = n1_ok && n2_ok;
        end
    end

endmodule

`default_nettype wire

>>> rtl/segment_rect_intersect.sv
// top level: pipelined segment versus axis-aligned rectangle hit test
// stages advance independently so bubbles fill; a low out_ready can stall them
// throughput: one request per cycle while the output is not stalled
// stages: offsets, ten narrow products, edge terms, edge compares into output register
// reset: rst_n clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module segment_rect_intersect
    import srect_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] seg_start_x,
    input  logic signed [COORD_BITS-1:0] seg_start_y,
    input  logic signed [COORD_BITS-1:0] seg_end_x,
    input  logic signed [COORD_BITS-1:0] seg_end_y,
    input  logic signed [COORD_BITS-1:0] rect_left,
    input  logic signed [COORD_BITS-1:0] rect_top,
    input  logic        [SIZE_W-1:0]     rect_width,
    input  logic        [SIZE_W-1:0]     rect_height,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         hit
);

    // stage valids and load enables
    logic v1_reg, v2_reg, v3_reg, vout_reg;
    logic ld1, ld2, ld3, ld4;

    // stage 1: differences and offsets
    logic signed [DIFF_W-1:0] sdx_reg, sdy_reg;
    logic signed [OFF_W-1:0]  ox_reg, oy_reg, oxr_reg, oyb_reg;
    logic signed [COORD_BITS-1:0] w_reg, h_reg;
    logic signed [OFF_W-1:0]  x1_e, y1_e, lx_e, ty_e, w_e, h_e;
    logic signed [OFF_W-1:0]  sdx_next, sdy_next, ox_next, oy_next, oxr_next, oyb_next;

    // stage 2: products
    logic signed [MUL_W-1:0] p_sdyw_reg, p_sdxh_reg;
    logic signed [MUL_W-1:0] p_oyw_reg, p_oybw_reg, p_oxh_reg, p_oxrh_reg;
    logic signed [MUL_W-1:0] p_oysdx_reg, p_oybsdx_reg, p_oxsdy_reg, p_oxrsdy_reg;

    // stage 3: per-edge terms
    edge_terms_t terms_reg [NUM_EDGES];
    edge_terms_t terms_next [NUM_EDGES];

    logic [NUM_EDGES-1:0] edge_hit;
    logic                 hit_reg;

    assign ld4      = !vout_reg || out_ready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    assign out_valid = vout_reg;
    assign hit       = hit_reg;

    always_comb
    begin
        x1_e = OFF_W'(seg_start_x);
        y1_e = OFF_W'(seg_start_y);
        lx_e = OFF_W'(rect_left);
        ty_e = OFF_W'(rect_top);
        w_e  = $signed(OFF_W'(rect_width));
        h_e  = $signed(OFF_W'(rect_height));
        sdx_next = OFF_W'(seg_end_x) - x1_e;
        sdy_next = OFF_W'(seg_end_y) - y1_e;
        ox_next  = x1_e - lx_e;
        oy_next  = y1_e - ty_e;
        oxr_next = x1_e - lx_e - w_e;
        oyb_next = y1_e - ty_e - h_e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                vout_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            sdx_reg <= DIFF_W'(sdx_next);
            sdy_reg <= DIFF_W'(sdy_next);
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            oxr_reg <= oxr_next;
            oyb_reg <= oyb_next;
            w_reg   <= COORD_BITS'(w_e);
            h_reg   <= COORD_BITS'(h_e);
        end
        if (ld2)
        begin
            p_sdyw_reg   <= MUL_W'(sdy_reg * w_reg);
            p_sdxh_reg   <= MUL_W'(sdx_reg * h_reg);
            p_oyw_reg    <= MUL_W'(oy_reg * w_reg);
            p_oybw_reg   <= MUL_W'(oyb_reg * w_reg);
            p_oxh_reg    <= MUL_W'(ox_reg * h_reg);
            p_oxrh_reg   <= MUL_W'(oxr_reg * h_reg);
            p_oysdx_reg  <= MUL_W'(oy_reg * sdx_reg);
            p_oybsdx_reg <= MUL_W'(oyb_reg * sdx_reg);
            p_oxsdy_reg  <= MUL_W'(ox_reg * sdy_reg);
            p_oxrsdy_reg <= MUL_W'(oxr_reg * sdy_reg);
        end
        if (ld3)
        begin
            terms_reg <= terms_next;
        end
        if (ld4)
        begin
            hit_reg <= |edge_hit;
        end
    end

    always_comb
    begin
        // horizontal edges: denominator -sdy*w
        terms_next[EDGE_TOP].den    = -TERM_W'(p_sdyw_reg);
        terms_next[EDGE_TOP].n1     = TERM_W'(p_oyw_reg);
        terms_next[EDGE_TOP].n2     = TERM_W'(p_oysdx_reg) - TERM_W'(p_oxsdy_reg);
        terms_next[EDGE_BOTTOM].den = -TERM_W'(p_sdyw_reg);
        terms_next[EDGE_BOTTOM].n1  = TERM_W'(p_oybw_reg);
        terms_next[EDGE_BOTTOM].n2  = TERM_W'(p_oybsdx_reg) - TERM_W'(p_oxsdy_reg);
        // vertical edges: denominator sdx*h
        terms_next[EDGE_LEFT].den   = TERM_W'(p_sdxh_reg);
        terms_next[EDGE_LEFT].n1    = -TERM_W'(p_oxh_reg);
        terms_next[EDGE_LEFT].n2    = TERM_W'(p_oysdx_reg) - TERM_W'(p_oxsdy_reg);
        terms_next[EDGE_RIGHT].den  = TERM_W'(p_sdxh_reg);
        terms_next[EDGE_RIGHT].n1   = -TERM_W'(p_oxrh_reg);
        terms_next[EDGE_RIGHT].n2   = TERM_W'(p_oysdx_reg) - TERM_W'(p_oxrsdy_reg);
    end

    for (genvar e = 0; e < NUM_EDGES; e++)
    begin : g_edge
        srect_edge_test u_edge (
            .terms (terms_reg[e]),
            .hit   (edge_hit[e])
        );
    end

endmodule

`default_nettype wire

>>> rtl/srect_checker.sv
// port-level checker for the segment/rectangle hit test, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module srect_checker
    import srect_pkg::*;
(
    input  wire clk,
    input  wire rst_n,
    input  wire in_valid,
    input  wire in_ready,
    input  wire out_valid,
    input  wire out_ready,
    input  wire hit
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit))
        else $error("result changed while stalled");

    // input only back-pressured by a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // fixed latency with a free-running output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("request did not reach the output in four cycles");

endmodule

bind segment_rect_intersect srect_checker u_srect_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
);

`default_nettype wire
